// File: sv/transition_pixel_source_mapper_assert.svh
// assertion helpers used by tpsm_back
`ifndef TRANSITION_PIXEL_SOURCE_MAPPER_ASSERT_SVH
`define TRANSITION_PIXEL_SOURCE_MAPPER_ASSERT_SVH

// same-cycle implication
`define TPSM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpsm assertion failed");

// next-cycle implication
`define TPSM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpsm assertion failed");

`endif

// File: sv/tpsm_pkg.sv
package tpsm_pkg;

  localparam int EASE_FRAC_BITS = 16;
  localparam int EASE_W = EASE_FRAC_BITS + 1;
  localparam int STEP_FRAC = 16;
  localparam int STEP_W = 28;
  localparam int DIM_W = 12;
  localparam int COORD_W = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int DOT_SHIFT = 24;

  localparam logic [1:0] REG_EFFECT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [3:0] EFF_DISSOLVE  = 4'd0;
  localparam logic [3:0] EFF_PUSH_LR   = 4'd1;
  localparam logic [3:0] EFF_PUSH_RL   = 4'd2;
  localparam logic [3:0] EFF_PUSH_TB   = 4'd3;
  localparam logic [3:0] EFF_PUSH_BT   = 4'd4;
  localparam logic [3:0] EFF_BLOCKS    = 4'd5;
  localparam logic [3:0] EFF_SPLIT     = 4'd6;
  localparam logic [3:0] EFF_TO_CENTER = 4'd7;
  localparam logic [3:0] EFF_SQUEEZE   = 4'd8;
  localparam logic [3:0] EFF_WIPE_LR   = 4'd9;
  localparam logic [3:0] EFF_WIPE_RL   = 4'd10;
  localparam logic [3:0] EFF_WIPE_TB   = 4'd11;
  localparam logic [3:0] EFF_WIPE_BT   = 4'd12;
  localparam logic [3:0] EFF_DOTS      = 4'd13;

  localparam logic [1:0] SRC_OLD   = 2'd0;
  localparam logic [1:0] SRC_NEW   = 2'd1;
  localparam logic [1:0] SRC_BLEND = 2'd2;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [8:0] BLOCK_LOW_ALL = 9'h1ff;
  localparam int BLOCK_STAGE_BASE = 10;
  localparam int BLOCK_STAGE_LEN = 28;
  localparam int STAGE_RECIP = ((1 << 16) + BLOCK_STAGE_LEN - 1) / BLOCK_STAGE_LEN;
  localparam int THIRD_RECIP = ((1 << 14) + 2) / 3;

  localparam logic [63:0] Q_ONE = 64'd1 << 60;
  localparam logic [63:0] Q_PI = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic                opcode;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [7:0]          progress;
    logic [7:0]          random_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          source_frame;
    logic [COORD_W-1:0]  source_x;
    logic [COORD_W-1:0]  source_y;
    logic [7:0]          blend_weight;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]    sfw;
    logic [DIM_W-1:0]    sfh;
    logic [COORD_W-1:0]  shw;
    logic [STEP_W-1:0]   side;
    logic [STEP_W-1:0]   mid;
    logic [2:0]          dexp;
    logic                ddir;
  } derived_t;

  typedef struct packed {
    logic                start;
    logic [7:0]          progress;
  } derive_req_t;

  typedef struct packed {
    logic [3:0]          effect;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [COORD_W-1:0]  tw;
    logic [COORD_W-1:0]  th;
  } frame_cfg_t;

  typedef logic [EASE_W-1:0] ease_tbl_t [256];

  // reciprocal of (2^e + 1) scaled by 2^24, rounded up
  function automatic logic [23:0] dot_recip(logic [2:0] e);
    logic [23:0] m;
    case (e)
      3'd0:    m = 24'd8388608;
      3'd1:    m = 24'd5592406;
      3'd2:    m = 24'd3355444;
      3'd3:    m = 24'd1864136;
      3'd4:    m = 24'd986896;
      3'd5:    m = 24'd508401;
      3'd6:    m = 24'd258112;
      default: m = 24'd130056;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] half_versine(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    int n;
    x = (Q_PI / 64'd255) * 64'(k);
    x2 = q_mul(x, x);
    term = Q_ONE;
    sum = Q_ONE;
    for (n = 1; n <= 13; n++) begin
      term = q_mul(term, x2) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > Q_ONE) sum = Q_ONE;
    return (Q_ONE - sum) >> 1;
  endfunction

  function automatic logic [EASE_W-1:0] ease_value(int k);
    logic [63:0] e;
    if (k > 127) e = Q_ONE - half_versine(255 - k);
    else e = half_versine(k);
    e = (e + (64'd1 << (59 - EASE_FRAC_BITS))) >> (60 - EASE_FRAC_BITS);
    return e[EASE_W-1:0];
  endfunction

  function automatic ease_tbl_t ease_table();
    ease_tbl_t t;
    int k;
    for (k = 0; k < 256; k++) t[k] = ease_value(k);
    return t;
  endfunction

endpackage

// File: sv/tpsm_front.sv
module tpsm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpsm_pkg::in_item_t  in_data,
  input  logic [11:0]         frame_w,
  input  logic [11:0]         frame_h,
  output logic                q_valid,
  output tpsm_pkg::in_item_t  q_head,
  input  logic                q_pop
);
  import tpsm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  in_item_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               take;
  logic               push;
  logic               in_frame;

  assign in_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign take = in_valid && !in_stall;
  // pixels outside the frame give no result, so they never reach the back end
  assign in_frame = ({1'b0, in_data.pixel_x} < frame_w) && ({1'b0, in_data.pixel_y} < frame_h);
  assign push = take && (in_data.opcode == OP_FRAME || in_frame);

  assign q_valid = (cnt_r != '0);
  assign q_head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// File: sv/tpsm_derive.sv
module tpsm_derive (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tpsm_pkg::derive_req_t  req,
  input  logic [11:0]            frame_w,
  input  logic [11:0]            frame_h,
  output logic                   busy,
  output tpsm_pkg::derived_t     dv
);
  import tpsm_pkg::*;

  localparam ease_tbl_t EASE_TBL = ease_table();
  localparam int PW = EASE_W + DIM_W;
  localparam int P5W = EASE_W + 3;

  localparam logic [2:0] D_IDLE  = 3'd0;
  localparam logic [2:0] D_ROM   = 3'd1;
  localparam logic [2:0] D_MUL   = 3'd2;
  localparam logic [2:0] D_SETUP = 3'd3;
  localparam logic [2:0] D_DIV   = 3'd4;

  logic [2:0]          st_r, st_nxt;
  logic [4:0]          cnt_r;
  logic [7:0]          prog_r;
  logic [EASE_W-1:0]   e_r;
  derived_t            dv_r, dv_nxt;
  logic [STEP_W-1:0]   n_r [2];
  logic [DIM_W-1:0]    rem_r [2];
  logic [DIM_W-1:0]    d_r [2];
  logic [STEP_W-1:0]   n_nxt [2];
  logic [DIM_W-1:0]    rem_nxt [2];
  logic [PW-1:0]       prod_w;
  logic [PW-1:0]       prod_h;
  logic [P5W-1:0]      prod5;
  logic [2:0]          e5;
  logic [DIM_W:0]      trial [2];
  logic                ge [2];

  assign busy = (st_r != D_IDLE) || req.start;
  assign dv = dv_r;

  assign prod_w = PW'(e_r) * PW'(frame_w);
  assign prod_h = PW'(e_r) * PW'(frame_h);
  assign prod5 = P5W'(e_r) * P5W'(5);
  assign e5 = prod5[EASE_FRAC_BITS +: 3];

  // one restoring step per cycle on both quotients
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_r[l], n_r[l][STEP_W-1]};
      ge[l] = (trial[l] >= {1'b0, d_r[l]});
      rem_nxt[l] = ge[l] ? DIM_W'(trial[l] - {1'b0, d_r[l]}) : trial[l][DIM_W-1:0];
      n_nxt[l] = {n_r[l][STEP_W-2:0], ge[l]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    dv_nxt = dv_r;
    case (st_r)
      D_IDLE: if (req.start) st_nxt = D_ROM;
      D_ROM: st_nxt = D_MUL;
      D_MUL: begin
        dv_nxt.sfw = prod_w[EASE_FRAC_BITS +: DIM_W];
        dv_nxt.sfh = prod_h[EASE_FRAC_BITS +: DIM_W];
        dv_nxt.shw = prod_w[EASE_FRAC_BITS+1 +: COORD_W];
        if (e5 < 3'd5) begin
          dv_nxt.ddir = 1'b0;
          dv_nxt.dexp = 3'd4 - e5;
        end else begin
          dv_nxt.ddir = 1'b1;
          dv_nxt.dexp = 3'd0;
        end
        st_nxt = D_SETUP;
      end
      D_SETUP: st_nxt = D_DIV;
      D_DIV: begin
        if (cnt_r == 5'(STEP_W - 1)) begin
          dv_nxt.side = (d_r[0] == '0) ? '0 : n_nxt[0];
          dv_nxt.mid = (d_r[1] == '0) ? '0 : n_nxt[1];
          st_nxt = D_IDLE;
        end
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
      dv_r <= '0;
    end else begin
      st_r <= st_nxt;
      dv_r <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == D_IDLE) prog_r <= req.progress;
    if (st_r == D_ROM) e_r <= EASE_TBL[prog_r];
    if (st_r == D_SETUP) begin
      n_r[0] <= STEP_W'({frame_w[DIM_W-1:1], STEP_FRAC'(0)});
      d_r[0] <= {1'b0, dv_r.shw};
      n_r[1] <= STEP_W'({frame_w, STEP_FRAC'(0)});
      d_r[1] <= frame_w - {dv_r.shw, 1'b0};
      rem_r[0] <= '0;
      rem_r[1] <= '0;
      cnt_r <= '0;
    end else if (st_r == D_DIV) begin
      n_r[0] <= n_nxt[0];
      n_r[1] <= n_nxt[1];
      rem_r[0] <= rem_nxt[0];
      rem_r[1] <= rem_nxt[1];
      cnt_r <= cnt_r + 5'd1;
    end
  end

endmodule

// File: sv/tpsm_back.sv
`include "transition_pixel_source_mapper_assert.svh"

module tpsm_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  tpsm_pkg::in_item_t     q_head,
  output logic                   q_pop,
  input  tpsm_pkg::frame_cfg_t   cfg,
  input  tpsm_pkg::derived_t     dv,
  input  logic                   derive_busy,
  output tpsm_pkg::derive_req_t  dreq,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tpsm_pkg::out_item_t    out_data
);
  import tpsm_pkg::*;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_PIX    = 3'd1;
  localparam logic [2:0] B_FMOD   = 3'd2;
  localparam logic [2:0] B_FAPPLY = 3'd3;
  localparam logic [2:0] B_FWAIT  = 3'd4;

  logic [2:0]          st_r, st_nxt;
  logic [19:0]         mask_r, mask_nxt;
  logic [7:0]          cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r;
  logic [COORD_W-1:0]  x_r, y_r, sq_r;
  logic [DIM_W-1:0]    qx_r, qy_r;
  logic [7:0]          dn_r;
  logic [3:0]          drem_r, dd_r;
  logic [2:0]          dcnt_r;
  logic [3:0]          stage_r;

  logic                out_free;
  logic                take_frame, take_pix;
  logic [19:0]         mask0;
  logic [3:0]          used_cnt;
  logic [23:0]         stage_prod;
  logic [19:0]         stage_bit;
  logic [4:0]          dtrial;
  logic                dge;
  logic [3:0]          pick;
  logic [3:0]          seen;
  logic                found;
  logic [DIM_W-1:0]    wm;
  logic [COORD_W-1:0]  sq_op;
  logic [STEP_W-1:0]   sq_step;
  logic [38:0]         sq_prod;
  logic [DIM_W-1:0]    vx_in, vy_in;
  logic [23:0]         recip;
  logic [35:0]         qx_prod, qy_prod;
  out_item_t           res;

  assign out_free = !out_valid_r || !out_stall;
  assign take_frame = (st_r == B_IDLE) && q_valid && !derive_busy && q_head.opcode == OP_FRAME;
  assign take_pix = (st_r == B_IDLE) && q_valid && !derive_busy && q_head.opcode == OP_PIXEL;
  assign q_pop = take_frame || take_pix;

  assign dreq.start = (st_r == B_FAPPLY);
  assign dreq.progress = cur_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // a new transition starts when progress falls back or the last one finished
  assign mask0 = (cur_r == 8'd255 || q_head.progress < cur_r) ? '0 : mask_r;
  always_comb begin
    used_cnt = '0;
    for (int b = 0; b < 9; b++) used_cnt = used_cnt + 4'(mask0[b]);
  end
  assign stage_prod = 24'(q_head.progress) * 24'(STAGE_RECIP);
  assign stage_bit = 20'd1 << (5'(BLOCK_STAGE_BASE) + 5'(stage_r));

  // random byte modulo free count, one bit per cycle
  assign dtrial = {drem_r, dn_r[7]};
  assign dge = (dtrial >= {1'b0, dd_r});

  // free block whose rank equals the remainder
  always_comb begin
    pick = '0;
    seen = '0;
    found = 1'b0;
    for (int b = 0; b < 9; b++) begin
      if (!mask_r[b] && !found) begin
        if (seen == drem_r) begin
          pick = 4'(b);
          found = 1'b1;
        end
        seen = seen + 4'd1;
      end
    end
  end

  // first pixel step: squeeze product and dot quotients
  assign wm = cfg.w - {1'b0, dv.shw};
  always_comb begin
    if ({1'b0, q_head.pixel_x} < {1'b0, dv.shw}) begin
      sq_op = q_head.pixel_x;
      sq_step = dv.side;
    end else if ({1'b0, q_head.pixel_x} < wm) begin
      sq_op = q_head.pixel_x - dv.shw;
      sq_step = dv.mid;
    end else begin
      sq_op = COORD_W'({1'b0, q_head.pixel_x} - wm);
      sq_step = dv.side;
    end
  end
  assign sq_prod = 39'(sq_op) * 39'(sq_step);
  assign vx_in = DIM_W'(q_head.pixel_x) + 12'd1;
  assign vy_in = DIM_W'(q_head.pixel_y) + 12'd1;
  assign recip = dot_recip(dv.dexp);
  assign qx_prod = 36'(vx_in) * 36'(recip);
  assign qy_prod = 36'(vy_in) * 36'(recip);

  // second pixel step: pick the source
  always_comb begin
    logic [12:0] x13, y13, w13, h13, iw, ih, ihw;
    logic [11:0] two_tw, two_th, vx, vy;
    logic [1:0]  col, row;
    logic [4:0]  bidx;
    logic [16:0] mx, my;
    logic        dot;
    x13 = 13'(x_r);
    y13 = 13'(y_r);
    w13 = 13'(cfg.w);
    h13 = 13'(cfg.h);
    iw = 13'(dv.sfw);
    ih = 13'(dv.sfh);
    ihw = 13'(dv.shw);
    two_tw = {cfg.tw, 1'b0};
    two_th = {cfg.th, 1'b0};
    col = (x_r < cfg.tw) ? 2'd0 : (12'(x_r) < two_tw) ? 2'd1 : 2'd2;
    row = (y_r < cfg.th) ? 2'd0 : (12'(y_r) < two_th) ? 2'd1 : 2'd2;
    bidx = {1'b0, row, 1'b0} + 5'(row) + 5'(col);
    vx = 12'(x_r) + 12'd1;
    vy = 12'(y_r) + 12'd1;
    mx = (17'(qx_r) << dv.dexp) + 17'(qx_r);
    my = (17'(qy_r) << dv.dexp) + 17'(qy_r);
    dot = (mx == 17'(vx)) && (my == 17'(vy));
    res.source_frame = SRC_NEW;
    res.source_x = x_r;
    res.source_y = y_r;
    res.blend_weight = '0;
    case (cfg.effect)
      EFF_DISSOLVE: begin
        res.source_frame = SRC_BLEND;
        res.blend_weight = cur_r;
      end
      EFF_PUSH_LR: begin
        if (x13 < iw) res.source_x = COORD_W'(x13 + w13 - iw);
        else begin
          res.source_frame = SRC_OLD;
          res.source_x = COORD_W'(x13 - iw);
        end
      end
      EFF_PUSH_RL: begin
        if (x13 < w13 - iw) begin
          res.source_frame = SRC_OLD;
          res.source_x = COORD_W'(x13 + iw);
        end else res.source_x = COORD_W'(x13 - (w13 - iw));
      end
      EFF_PUSH_TB: begin
        if (y13 < ih) res.source_y = COORD_W'(y13 + h13 - ih);
        else begin
          res.source_frame = SRC_OLD;
          res.source_y = COORD_W'(y13 - ih);
        end
      end
      EFF_PUSH_BT: begin
        if (y13 < h13 - ih) begin
          res.source_frame = SRC_OLD;
          res.source_y = COORD_W'(y13 + ih);
        end else res.source_y = COORD_W'(y13 - (h13 - ih));
      end
      EFF_BLOCKS: res.source_frame = {1'b0, mask_r[bidx]};
      EFF_SPLIT: begin
        if (y13 < (h13 >> 1)) begin
          if (x13 < iw) res.source_x = COORD_W'(x13 + w13 - iw);
          else begin
            res.source_frame = SRC_OLD;
            res.source_x = COORD_W'(x13 - iw);
          end
        end else begin
          if (x13 < w13 - iw) begin
            res.source_frame = SRC_OLD;
            res.source_x = COORD_W'(x13 + iw);
          end else res.source_x = COORD_W'(x13 - (w13 - iw));
        end
      end
      EFF_TO_CENTER: begin
        if (x13 < ihw) res.source_x = COORD_W'(w13 - ihw - (w13 >> 1) + x13);
        else if (x13 < w13 - ihw) res.source_frame = SRC_OLD;
        else res.source_x = COORD_W'((w13 >> 1) + x13 - (w13 - ihw));
      end
      EFF_SQUEEZE: begin
        if (x13 < ihw) res.source_x = sq_r;
        else if (x13 < w13 - ihw) begin
          res.source_frame = SRC_OLD;
          res.source_x = sq_r;
        end else res.source_x = COORD_W'((w13 >> 1) + 13'(sq_r));
      end
      EFF_WIPE_LR: res.source_frame = (x13 < iw) ? SRC_NEW : SRC_OLD;
      EFF_WIPE_RL: res.source_frame = (x13 < w13 - iw) ? SRC_OLD : SRC_NEW;
      EFF_WIPE_TB: res.source_frame = (y13 < ih) ? SRC_NEW : SRC_OLD;
      EFF_WIPE_BT: res.source_frame = (y13 < h13 - ih) ? SRC_OLD : SRC_NEW;
      EFF_DOTS: begin
        if (dv.ddir) res.source_frame = dot ? SRC_OLD : SRC_NEW;
        else res.source_frame = dot ? SRC_NEW : SRC_OLD;
      end
      default: res.source_frame = SRC_NEW;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    mask_nxt = mask_r;
    cur_nxt = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      B_IDLE: begin
        if (take_frame) begin
          mask_nxt = mask0;
          cur_nxt = q_head.progress;
          st_nxt = B_FMOD;
        end else if (take_pix) begin
          st_nxt = B_PIX;
        end
      end
      B_PIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      B_FMOD: if (dcnt_r == 3'd7) st_nxt = B_FAPPLY;
      B_FAPPLY: begin
        if (cfg.effect == EFF_BLOCKS && (mask_r & stage_bit) == '0) begin
          if (mask_r[8:0] == BLOCK_LOW_ALL) mask_nxt = mask_r | stage_bit | 20'd1;
          else mask_nxt = mask_r | stage_bit | (20'd1 << pick);
        end
        st_nxt = B_FWAIT;
      end
      B_FWAIT: if (!derive_busy) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      mask_r <= '0;
      cur_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      mask_r <= mask_nxt;
      cur_r <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix) begin
      x_r <= q_head.pixel_x;
      y_r <= q_head.pixel_y;
      sq_r <= sq_prod[STEP_FRAC +: COORD_W];
      qx_r <= qx_prod[DOT_SHIFT +: DIM_W];
      qy_r <= qy_prod[DOT_SHIFT +: DIM_W];
    end
    if (take_frame) begin
      dn_r <= q_head.random_byte;
      dd_r <= 4'd9 - used_cnt;
      drem_r <= '0;
      dcnt_r <= '0;
      stage_r <= stage_prod[16 +: 4];
    end else if (st_r == B_FMOD) begin
      dn_r <= {dn_r[6:0], 1'b0};
      drem_r <= dge ? 4'(dtrial - {1'b0, dd_r}) : dtrial[3:0];
      dcnt_r <= dcnt_r + 3'd1;
    end
    if (st_r == B_PIX && out_free) out_r <= res;
  end

  `TPSM_ASSERT_NXT(a_apply_starts_derive, st_r == B_FAPPLY, derive_busy)
  `TPSM_ASSERT_NXT(a_stage_marked, st_r == B_FAPPLY && cfg.effect == EFF_BLOCKS, (mask_r & stage_bit) != '0)
  `TPSM_ASSERT_IMP(a_out_code, out_valid_r, out_r.source_frame == SRC_OLD || out_r.source_frame == SRC_NEW || out_r.source_frame == SRC_BLEND)
  `TPSM_ASSERT_IMP(a_pop_from_idle, q_pop, q_valid && st_r == B_IDLE)

endmodule

// File: sv/transition_pixel_source_mapper.sv
// Maps each output pixel of a frame transition to its source: old frame, new frame or
// a blend. A frame-start item (opcode 0) updates the per-frame state and gives no
// result; it occupies the back end while that state is recomputed, mostly in the two
// 28-step restoring dividers that form the squeeze steps. A pixel query (opcode 1)
// passes a registered multiply step in the back end, then the source select into the
// output register, which waits while the output stalls; queries outside the frame are
// dropped at the input. A 4-entry queue lets the input keep accepting while the back
// end works. Writing frame_width or frame_height recomputes the per-frame state, and
// queued items wait meanwhile. There is no clearing pass after reset.
module transition_pixel_source_mapper #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tpsm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tpsm_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [11:0]          cfg_data
);
  import tpsm_pkg::*;

  logic [3:0]          effect_r;
  logic [DIM_W-1:0]    fw_r, fh_r;
  logic                kick_r;
  logic [COORD_W-1:0]  tw_r, th_r;
  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [25:0]         tw_prod, th_prod;
  logic                q_valid, q_pop, derive_busy;
  in_item_t            q_head;
  derived_t            dv;
  derive_req_t         back_req, dreq;
  frame_cfg_t          cfg;

  always_comb begin
    if (fw_r == '0) w_eff = 12'd1;
    else if ({1'b0, fw_r} > 13'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
    else w_eff = fw_r;
    if (fh_r == '0) h_eff = 12'd1;
    else if ({1'b0, fh_r} > 13'(MAX_HEIGHT)) h_eff = 12'(MAX_HEIGHT);
    else h_eff = fh_r;
  end

  // tile size for the nine-block effect, a third of each dimension
  assign tw_prod = 26'(w_eff) * 26'(THIRD_RECIP);
  assign th_prod = 26'(h_eff) * 26'(THIRD_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r <= EFF_DISSOLVE;
      fw_r <= 12'd640;
      fh_r <= 12'd480;
      kick_r <= 1'b0;
    end else begin
      kick_r <= cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
      if (cfg_we) begin
        case (cfg_index)
          REG_EFFECT: effect_r <= cfg_data[3:0];
          REG_WIDTH:  fw_r <= cfg_data;
          REG_HEIGHT: fh_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tw_r <= tw_prod[14 +: COORD_W];
    th_r <= th_prod[14 +: COORD_W];
  end

  assign cfg = '{effect: effect_r, w: w_eff, h: h_eff, tw: tw_r, th: th_r};
  assign dreq = '{start: back_req.start || kick_r, progress: back_req.progress};

  tpsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .frame_w  (w_eff),
    .frame_h  (h_eff),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  tpsm_derive u_derive (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dreq),
    .frame_w (w_eff),
    .frame_h (h_eff),
    .busy    (derive_busy),
    .dv      (dv)
  );

  tpsm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .cfg         (cfg),
    .dv          (dv),
    .derive_busy (derive_busy),
    .dreq        (back_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
